// ===== sv/grr_pkg.sv =====
// ----------------------------------------------------------------------------
// grr_pkg
// shared constants, controller states and control/status types for the
// group reverse reorder block
// ----------------------------------------------------------------------------
package grr_pkg;

  localparam int MAX_GROUP = 16;
  localparam int ADDR_W    = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int GS_W      = 5;
  localparam int VAL_W     = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SHOW
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;
    logic shown_last;
  } sts_t;

endpackage

// ===== sv/group_reverse_reorder_top.sv =====
// ----------------------------------------------------------------------------
// group_reverse_reorder_top
// reorders a stream of 32-bit values, reversing each full group of
// group_size items (0 read as 1, above 16 as 16) and passing a trailing partial group in order
// ----------------------------------------------------------------------------
//   channel | ports                                         | direction
//   in      | in_valid in_stall in_value in_is_final        | input transfer
//   out     | out_valid out_stall out_value_res out_run_end | result transfer
//           | out_list_end                                  |
//   cfg     | cfg_we cfg_data                               | group size write
//
// an input item that emits nothing is only accepted; one that emits n results
// is accepted, then the store is read, then the n results are shown in turn
// store reads go through the single read port, one result per cycle while out_stall is low
// out_stall holds the current result and the store read for the next one
// reset clears fill count and state and sets group size to 1; no clearing pass
// ----------------------------------------------------------------------------
module group_reverse_reorder_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [grr_pkg::VAL_W-1:0] in_value,
  input  logic                             in_is_final,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [grr_pkg::VAL_W-1:0] out_value_res,
  output logic                             out_run_end,
  output logic                             out_list_end,
  input  logic                             cfg_we,
  input  logic [grr_pkg::GS_W-1:0]         cfg_data
);

  grr_pkg::cmd_t cmd;
  grr_pkg::sts_t sts;

  grr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  grr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_value      (in_value),
    .in_is_final   (in_is_final),
    .out_value_res (out_value_res),
    .out_run_end   (out_run_end),
    .out_list_end  (out_list_end),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ===== sv/grr_ram.sv =====
// ----------------------------------------------------------------------------
// grr_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module grr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/grr_ctrl.sv =====
// ----------------------------------------------------------------------------
// grr_ctrl
// controller: takes one input transfer and, if it emits a group, drains that
// group while out_stall is low, one result per cycle
// ----------------------------------------------------------------------------
module grr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output grr_pkg::cmd_t cmd,
  input  grr_pkg::sts_t sts
);

  grr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      grr_pkg::ST_IDLE: begin
        if (in_valid && sts.emit) state_nxt = grr_pkg::ST_FETCH;
      end
      grr_pkg::ST_FETCH: begin
        state_nxt = grr_pkg::ST_SHOW;
      end
      grr_pkg::ST_SHOW: begin
        if (!out_stall && sts.shown_last) state_nxt = grr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = grr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd_en  = 1'b0;
    case (state_r)
      grr_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      grr_pkg::ST_FETCH: begin
        cmd.rd_en = 1'b1;
      end
      grr_pkg::ST_SHOW: begin
        out_valid = 1'b1;
        cmd.rd_en = !out_stall && !sts.shown_last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && sts.shown_last) |=> !in_stall && !out_valid)
    else $error("controller did not return to idle after last result");

endmodule

// ===== sv/grr_dp.sv =====
// ----------------------------------------------------------------------------
// grr_dp
// datapath: group size register, fill count, group store and read sequencing
// ----------------------------------------------------------------------------
module grr_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [grr_pkg::GS_W-1:0]         cfg_data,
  input  logic signed [grr_pkg::VAL_W-1:0] in_value,
  input  logic                             in_is_final,
  output logic signed [grr_pkg::VAL_W-1:0] out_value_res,
  output logic                             out_run_end,
  output logic                             out_list_end,
  input  grr_pkg::cmd_t                    cmd,
  output grr_pkg::sts_t                    sts
);

  logic [grr_pkg::GS_W-1:0]   group_size_r;
  logic [grr_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [grr_pkg::CNT_W-1:0]  n_r, idx_r;
  logic                       rev_r, fin_r;
  logic                       run_end_r, list_end_r;
  logic [grr_pkg::CNT_W-1:0]  k, fill_inc, rd_off;
  logic                       rev_now;
  logic                       last_rd;
  logic [grr_pkg::VAL_W-1:0]  rdata;

  always_comb begin
    if (group_size_r == '0) begin
      k = grr_pkg::CNT_W'(1);
    end else if (32'(group_size_r) > 32'(grr_pkg::MAX_GROUP)) begin
      k = grr_pkg::CNT_W'(grr_pkg::MAX_GROUP);
    end else begin
      k = grr_pkg::CNT_W'(group_size_r);
    end
  end

  assign fill_inc = fill_r + grr_pkg::CNT_W'(1);
  assign rev_now  = (fill_inc >= k);
  assign sts.emit = rev_now || in_is_final;
  assign sts.shown_last = run_end_r;

  assign fill_nxt = (cmd.accept && sts.emit) ? '0 :
                    cmd.accept               ? fill_inc : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= grr_pkg::GS_W'(1);
      fill_r       <= '0;
    end else begin
      if (cfg_we) group_size_r <= cfg_data;
      fill_r <= fill_nxt;
    end
  end

  assign last_rd = (idx_r == n_r - grr_pkg::CNT_W'(1));
  assign rd_off  = rev_r ? (n_r - grr_pkg::CNT_W'(1) - idx_r) : idx_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.emit) begin
      n_r   <= fill_inc;
      rev_r <= rev_now;
      fin_r <= in_is_final;
      idx_r <= '0;
    end else if (cmd.rd_en) begin
      idx_r <= idx_r + grr_pkg::CNT_W'(1);
    end
    if (cmd.rd_en) begin
      run_end_r  <= last_rd;
      list_end_r <= last_rd && fin_r;
    end
  end

  grr_ram #(
    .WIDTH (grr_pkg::VAL_W),
    .DEPTH (grr_pkg::MAX_GROUP)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (fill_r[grr_pkg::ADDR_W-1:0]),
    .wdata (in_value),
    .re    (cmd.rd_en),
    .raddr (rd_off[grr_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign out_value_res = rdata;
  assign out_run_end   = run_end_r;
  assign out_list_end  = list_end_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) < grr_pkg::MAX_GROUP)
    else $error("fill count reached store depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !sts.emit) |=> (fill_r == $past(fill_r) + grr_pkg::CNT_W'(1)))
    else $error("fill count did not advance");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> (idx_r <= n_r))
    else $error("read index ran past group");

endmodule

// ===== verif/group_reverse_reorder_top_test.sv =====
// ----------------------------------------------------------------------------
// group_reverse_reorder_top_test
// self-checking testbench for the group reverse reorder block: a directed
// table (value extremes, pass-through, zero and oversized group size, partial
// and completed final groups, size lowered mid-group) followed by random
// lists over several group sizes and idle profiles, each result transfer
// compared field by field against an in-order prediction of the reordering
// ----------------------------------------------------------------------------
module group_reverse_reorder_top_test;

  localparam int DIR_ROWS     = 22;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 31;
  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES   = 24;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic signed [grr_pkg::VAL_W-1:0] value;
    logic                             run_end;
    logic                             list_end;
  } res_t;

  typedef struct packed {
    logic                      wr_cfg;
    logic [grr_pkg::GS_W-1:0]  cfg;
    logic [grr_pkg::VAL_W-1:0] value;
    logic                      fin;
    logic                      typed;
    res_t                      want;
  } dir_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic signed [grr_pkg::VAL_W-1:0] in_value = '0;
  logic                             in_is_final = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [grr_pkg::VAL_W-1:0] out_value_res;
  logic                             out_run_end;
  logic                             out_list_end;
  logic                             cfg_we = 1'b0;
  logic [grr_pkg::GS_W-1:0]         cfg_data = '0;

  logic [grr_pkg::VAL_W-1:0] group_mem [grr_pkg::MAX_GROUP];
  int                        fill_cnt = 0;
  logic [grr_pkg::GS_W-1:0]  group_size_reg = 5'd1;
  res_t                      pending_results [$];
  res_t                      head_res;
  dir_row_t                  dir_tab [DIR_ROWS];

  int err_cnt      = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int lists_closed = 0;
  int idle_cycles  = 0;
  int src_pct      = 0;
  int sink_pct     = 0;

  group_reverse_reorder_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_is_final   (in_is_final),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value_res (out_value_res),
    .out_run_end   (out_run_end),
    .out_list_end  (out_list_end),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int eff_group(input logic [grr_pkg::GS_W-1:0] g);
    int k;
    k = int'(g);
    if (k == 0) k = 1;
    if (k > grr_pkg::MAX_GROUP) k = grr_pkg::MAX_GROUP;
    return k;
  endfunction

  task automatic reorder_predict(input logic [grr_pkg::VAL_W-1:0] v, input logic fin,
                                 input bit keep);
    int   k;
    int   n;
    bit   rev;
    res_t r;
    k = eff_group(group_size_reg);
    if (fill_cnt < grr_pkg::MAX_GROUP) begin
      group_mem[fill_cnt] = v;
      fill_cnt++;
    end
    if (fill_cnt >= k) rev = 1'b1;
    else if (fin) rev = 1'b0;
    else return;
    n = fill_cnt;
    for (int i = 0; i < n; i++) begin
      r.value    = group_mem[rev ? (n - 1 - i) : i];
      r.run_end  = (i + 1 == n);
      r.list_end = (i + 1 == n) && fin;
      if (keep) pending_results.push_back(r);
    end
    fill_cnt = 0;
  endtask

  task automatic report_mismatch(input string what, input logic [grr_pkg::VAL_W-1:0] got,
                                 input logic [grr_pkg::VAL_W-1:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
             results_seen);
    err_cnt++;
  endtask

  // caller is at a falling edge; returns at a falling edge
  task automatic send_item(input logic [grr_pkg::VAL_W-1:0] v, input logic fin,
                           input logic typed, input res_t want);
    while (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_value    <= v;
    in_is_final <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (typed) begin
      reorder_predict(v, fin, 1'b0);
      pending_results.push_back(want);
    end else begin
      reorder_predict(v, fin, 1'b1);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_group_size(input logic [grr_pkg::GS_W-1:0] g);
    cfg_we         <= 1'b1;
    cfg_data       <= g;
    group_size_reg = g;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [grr_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  always @(negedge clk) begin
    out_stall <= (sink_pct != 0) && ($urandom_range(0, 99) < sink_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_value_res, '0);
      end else begin
        head_res = pending_results.pop_front();
        if (out_value_res !== head_res.value)
          report_mismatch("value_res", out_value_res, head_res.value);
        if (out_run_end !== head_res.run_end)
          report_mismatch("run_end", 32'(out_run_end), 32'(head_res.run_end));
        if (out_list_end !== head_res.list_end)
          report_mismatch("list_end", 32'(out_list_end), 32'(head_res.list_end));
        if (head_res.list_end) lists_closed++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    int                       phase_cnt;
    int                       len;
    int                       kind;
    int                       keff;
    logic [grr_pkg::GS_W-1:0] gs;
    logic                     fin;
    dir_tab = '{
      '{1'b0, 5'd0,  32'h7fff_ffff, 1'b0, 1'b1, '{32'h7fff_ffff, 1'b1, 1'b0}},
      '{1'b0, 5'd0,  32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b1}},
      '{1'b0, 5'd0,  32'h0000_0000, 1'b0, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
      '{1'b0, 5'd0,  32'hffff_ffff, 1'b1, 1'b1, '{32'hffff_ffff, 1'b1, 1'b1}},
      // zero group size passes through
      '{1'b1, 5'd0,  32'h1234_5678, 1'b1, 1'b1, '{32'h1234_5678, 1'b1, 1'b1}},
      '{1'b1, 5'd3,  32'h0000_0011, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'h0000_0022, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'h0000_0033, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'h0000_0044, 1'b0, 1'b0, '0},
      // partial final group in arrival order
      '{1'b0, 5'd0,  32'h0000_0055, 1'b1, 1'b0, '0},
      '{1'b0, 5'd0,  32'h0000_0066, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'h0000_0077, 1'b0, 1'b0, '0},
      // final item completes a group
      '{1'b0, 5'd0,  32'h0000_0088, 1'b1, 1'b0, '0},
      '{1'b1, 5'd5,  32'ha000_0001, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'ha000_0002, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'ha000_0003, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'ha000_0004, 1'b0, 1'b0, '0},
      // size lowered below the fill count
      '{1'b1, 5'd2,  32'ha000_0005, 1'b0, 1'b0, '0},
      // oversized group size saturates
      '{1'b1, 5'd31, 32'hb000_0001, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'hb000_0002, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'hb000_0003, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  32'hb000_0004, 1'b1, 1'b0, '0}
    };

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].wr_cfg) begin
        wait_drained(DRAIN_CYCLES);
        write_group_size(dir_tab[r].cfg);
      end
      send_item(dir_tab[r].value, dir_tab[r].fin, dir_tab[r].typed, dir_tab[r].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: gs = 5'd16;
        1: gs = 5'd1;
        2: gs = 5'd31;
        3: gs = 5'd4;
        4: gs = 5'd0;
        5: gs = 5'd17;
        default: gs = 5'($urandom_range(0, 31));
      endcase
      wait_drained(DRAIN_CYCLES);
      write_group_size(gs);
      case (p % 4)
        0: begin src_pct = 0;  sink_pct = 0;  end
        1: begin src_pct = 74; sink_pct = 0;  end
        2: begin src_pct = 0;  sink_pct = 74; end
        default: begin src_pct = 23; sink_pct = 23; end
      endcase
      keff      = eff_group(gs);
      phase_cnt = 0;
      while (phase_cnt < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        len  = $urandom_range(1, 2 * keff + 1);
        for (int i = 0; i < len && phase_cnt < PHASE_ITEMS; i++) begin
          case (kind)
            0: fin = 1'b0;
            1: fin = 1'($urandom_range(0, 1));
            default: fin = (i == len - 1);
          endcase
          send_item(rand_value(), fin, 1'b0, '0);
          phase_cnt++;
        end
        // sender now and then holds off until every predicted result has been taken
        if ($urandom_range(0, 7) == 0) wait_drained(0);
      end
    end

    src_pct = 0;
    wait_drained(END_CYCLES);
    sink_pct = 0;

    $display("run covered %0d input transfers and %0d result transfers (%0d lists closed)",
             items_sent, results_seen, lists_closed);
    $display("over %0d group-size settings with four sender/receiver idle profiles",
             PHASES + 5);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
